>>> hw/rtl/fbpa_pkg.sv
// fbpa_pkg: shared types, codes and helpers for the fixed block pool allocator
// depends on: nothing
`default_nettype none
package fbpa_pkg;

  localparam int DEF_POOL_DEPTH = 1024;

  localparam int ADDR_W   = 32;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 11;
  localparam int SIZE_W   = 17;
  localparam int LIM_W    = 11;
  localparam int CFG_IDX_W = 2;

  localparam int MIN_SHIFT  = 2;
  localparam int MAX_SHIFT  = 17;
  localparam int SHIFT_W    = 5;
  localparam int SIZE_EXT_W = SIZE_W + 1;
  localparam int SPAN_W     = LIM_W + MAX_SHIFT;

  localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REBUILD = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_NOP     = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK             = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE        = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NONE_ALLOCATED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REBUILT        = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_OBJECTS  = 2'd2;

  localparam logic [ADDR_W-1:0]  RST_BASE_ADDRESS = '0;
  localparam logic [SHIFT_W-1:0] RST_SHIFT        = 5'd2;
  localparam logic [LIM_W-1:0]   RST_MAX_OBJECTS  = 11'd1024;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   block_address;
  } fbpa_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   granted_address;
    logic [COUNT_W-1:0]  allocated_count;
  } fbpa_out_t;

  // log2 of the object size rounded up to a power of two of at least four
  function automatic logic [SHIFT_W-1:0] stride_shift(input logic [SIZE_W-1:0] size);
    logic [SHIFT_W-1:0] sh;
    sh = SHIFT_W'(MAX_SHIFT);
    for (int k = MAX_SHIFT - 1; k >= MIN_SHIFT; k--) begin
      if ((SIZE_EXT_W'(1) << k) >= SIZE_EXT_W'(size)) begin
        sh = SHIFT_W'(k);
      end
    end
    return sh;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/fbpa_ram.sv
// fbpa_ram: generic simple dual-port ram, one write and one registered read port
// depends on: nothing
`default_nettype none
module fbpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/fixed_block_pool_allocator.sv
// fixed_block_pool_allocator: block allocator with a fifo free list held in one ram
// depends on: fbpa_pkg, fbpa_ram
//
// Each command accepted (start high, busy low) gives exactly one result, shown for one
// cycle with out_strobe; the receiver cannot stall it. Allocate, free and no-op hold
// busy in the execute state only and strobe their result from the result register,
// so a new command can be taken once execute is over: the free-list ram is read at
// the ring head in the accept cycle and updated in the next. Rebuild writes one ring
// entry per cycle, holding busy until it has written limit entries, where limit is
// max_objects clamped to 1..POOL_DEPTH, and strobes its result in the cycle after the
// last write. The ring needs no clearing after reset. Configuration writes are always
// taken (cfg_ready high) and are meant for idle periods only.
`default_nettype none
module fixed_block_pool_allocator #(
  parameter int POOL_DEPTH = fbpa_pkg::DEF_POOL_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire fbpa_pkg::fbpa_in_t          in_item,
  output logic                             out_strobe,
  output fbpa_pkg::fbpa_out_t              out_result,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fbpa_pkg::ADDR_W-1:0]    cfg_data
);

  import fbpa_pkg::*;

  localparam int IDX_W = $clog2(POOL_DEPTH);
  localparam int CNT_W = $clog2(POOL_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FILL = 2'd2;

  logic [1:0]         state_r, state_nxt;
  fbpa_in_t           item_r, item_nxt;
  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic [LIM_W-1:0]   max_obj_r, max_obj_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic [ADDR_W-1:0]  acc_r, acc_nxt;
  logic               strobe_r, strobe_nxt;
  fbpa_out_t          result_r, result_nxt;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]  wr_data;
  logic [ADDR_W-1:0]  rd_data;

  logic [LIM_W-1:0]   limit;
  logic [LIM_W-1:0]   limit_m1;
  logic [SPAN_W-1:0]  span;
  logic [ADDR_W:0]    top;
  logic               outside;
  logic               at_limit;
  logic               ring_full;
  logic [ADDR_W-1:0]  stride;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(POOL_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  fbpa_ram #(
    .WIDTH(ADDR_W),
    .DEPTH(POOL_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (head_r),
    .rd_data (rd_data)
  );

  always_comb begin
    if (max_obj_r == '0) begin
      limit = LIM_W'(1);
    end else if (32'(max_obj_r) > 32'(POOL_DEPTH)) begin
      limit = LIM_W'(POOL_DEPTH);
    end else begin
      limit = max_obj_r;
    end
    limit_m1  = limit - 1'b1;
    span      = SPAN_W'(limit_m1) << shift_r;
    top       = (ADDR_W + 1)'(base_r) + (ADDR_W + 1)'(span);
    outside   = (item_r.block_address < base_r) ||
                ((ADDR_W + 1)'(item_r.block_address) > top);
    at_limit  = 32'(used_r) >= 32'(limit);
    ring_full = fill_r == CNT_W'(POOL_DEPTH);
    stride    = ADDR_W'(1) << shift_r;
  end

  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    base_nxt    = base_r;
    shift_nxt   = shift_r;
    max_obj_nxt = max_obj_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    fill_nxt    = fill_r;
    used_nxt    = used_r;
    acc_nxt     = acc_r;
    strobe_nxt  = 1'b0;
    result_nxt  = result_r;
    wr_en       = 1'b0;
    wr_addr     = tail_r;
    wr_data     = item_r.block_address;

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_BASE_ADDRESS: base_nxt    = cfg_data;
        REG_OBJECT_SIZE:  shift_nxt   = stride_shift(cfg_data[SIZE_W-1:0]);
        REG_MAX_OBJECTS:  max_obj_nxt = cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt  = in_item;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        result_nxt.status          = ST_OK;
        result_nxt.granted_address = '0;
        strobe_nxt                 = 1'b1;
        state_nxt                  = S_IDLE;
        case (item_r.action)
          ACT_ALLOC: begin
            if (at_limit || fill_r == '0) begin
              result_nxt.status = ST_EXHAUSTED;
            end else begin
              result_nxt.granted_address = rd_data;
              head_nxt = next_slot(head_r);
              fill_nxt = fill_r - 1'b1;
              used_nxt = used_r + 1'b1;
            end
          end
          ACT_FREE: begin
            if (outside) begin
              result_nxt.status = ST_OUTSIDE;
            end else if (used_r == '0) begin
              result_nxt.status = ST_NONE_ALLOCATED;
            end else begin
              if (!ring_full) begin
                wr_en    = 1'b1;
                tail_nxt = next_slot(tail_r);
                fill_nxt = fill_r + 1'b1;
              end
              used_nxt = used_r - 1'b1;
            end
          end
          ACT_REBUILD: begin
            strobe_nxt = 1'b0;
            head_nxt   = '0;
            tail_nxt   = '0;
            fill_nxt   = '0;
            used_nxt   = '0;
            acc_nxt    = base_r;
            state_nxt  = S_FILL;
          end
          default: ;
        endcase
        result_nxt.allocated_count = COUNT_W'(used_nxt);
      end
      S_FILL: begin
        wr_en    = 1'b1;
        wr_data  = acc_r;
        tail_nxt = next_slot(tail_r);
        fill_nxt = fill_r + 1'b1;
        acc_nxt  = acc_r + stride;
        if (32'(fill_r) + 32'd1 == 32'(limit)) begin
          strobe_nxt                 = 1'b1;
          result_nxt.status          = ST_REBUILT;
          result_nxt.granted_address = '0;
          result_nxt.allocated_count = COUNT_W'(used_r);
          state_nxt                  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      base_r    <= RST_BASE_ADDRESS;
      shift_r   <= RST_SHIFT;
      max_obj_r <= RST_MAX_OBJECTS;
      head_r    <= '0;
      tail_r    <= '0;
      fill_r    <= '0;
      used_r    <= '0;
      strobe_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      base_r    <= base_nxt;
      shift_r   <= shift_nxt;
      max_obj_r <= max_obj_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      fill_r    <= fill_nxt;
      used_r    <= used_nxt;
      strobe_r  <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    acc_r    <= acc_nxt;
    result_r <= result_nxt;
  end

  assign busy       = state_r != S_IDLE;
  assign cfg_ready  = 1'b1;
  assign out_strobe = strobe_r;
  assign out_result = result_r;

  a_ring_budget: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) + 32'(used_r) <= 32'(POOL_DEPTH))
    else $error("free ring and allocated count exceed pool depth");

  a_empty_ring: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r == '0 |-> head_r == tail_r)
    else $error("empty ring with head and tail apart");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> state_r == S_IDLE)
    else $error("result strobed while a transaction is still running");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> state_r == S_EXEC)
    else $error("accepted transaction did not reach execute");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FILL |-> 32'(fill_r) < 32'(limit) && used_r == '0)
    else $error("rebuild ran past the block limit");

endmodule
`default_nettype wire

>>> tb/sv/fixed_block_pool_allocator_tb.sv
// fixed_block_pool_allocator_tb: self-checking testbench for the fixed block pool allocator
// drives commands and register writes, predicts every result in a local free-list model
// depends on: fbpa_pkg, fixed_block_pool_allocator
`default_nettype none
module fixed_block_pool_allocator_tb;
  import fbpa_pkg::*;

  localparam int POOL_SLOTS  = DEF_POOL_DEPTH;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int PRINT_LIMIT = 40;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  fbpa_in_t             in_item;
  logic                 out_strobe;
  fbpa_out_t            out_result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;

  fixed_block_pool_allocator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_result (out_result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // register shadows
  logic [ADDR_W-1:0] reg_base = RST_BASE_ADDRESS;
  logic [SIZE_W-1:0] reg_size = SIZE_W'(4);
  logic [LIM_W-1:0]  reg_max  = RST_MAX_OBJECTS;

  // free-list model
  logic [ADDR_W-1:0] free_slots [POOL_SLOTS];
  int unsigned       slot_head  = 0;
  int unsigned       slot_tail  = 0;
  int unsigned       slot_fill  = 0;
  int unsigned       live_count = 0;

  fbpa_out_t         pending_results[$];
  logic [ADDR_W-1:0] held_blocks[$];
  int                sender_idle_pct = 34;
  int                mismatch_count  = 0;
  int                cycle_count     = 0;

  int n_alloc_cmds = 0, n_free_cmds = 0, n_rebuild_cmds = 0, n_nop_cmds = 0;
  int n_granted = 0, n_exhausted = 0, n_outside = 0, n_none_allocated = 0;

  function automatic int unsigned block_limit();
    if (reg_max == 0) return 1;
    if (reg_max > POOL_SLOTS) return POOL_SLOTS;
    return 32'(reg_max);
  endfunction

  function automatic logic [ADDR_W-1:0] block_stride(input logic [SIZE_W-1:0] size);
    logic [ADDR_W-1:0] p;
    p = 32'd4;
    while (p < 32'(size) && p < 32'h8000_0000) p = p << 1;
    return p;
  endfunction

  // highest block address, saturated at the top of the address space
  function automatic logic [ADDR_W-1:0] pool_top();
    logic [63:0] top;
    top = 64'(reg_base) + 64'(block_limit() - 1) * 64'(block_stride(reg_size));
    return (top > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : top[ADDR_W-1:0];
  endfunction

  function automatic void push_free_slot(input logic [ADDR_W-1:0] addr);
    if (slot_fill >= POOL_SLOTS) return;
    free_slots[slot_tail] = addr;
    slot_tail = (slot_tail + 1) % POOL_SLOTS;
    slot_fill++;
  endfunction

  task automatic apply_command(input fbpa_in_t cmd, output fbpa_out_t res);
    int unsigned       lim;
    logic [ADDR_W-1:0] stride;
    lim = block_limit();
    stride = block_stride(reg_size);
    res = '0;
    res.status = ST_OK;
    case (cmd.action)
      ACT_ALLOC: begin
        n_alloc_cmds++;
        if (live_count >= lim || slot_fill == 0) begin
          res.status = ST_EXHAUSTED;
        end else begin
          res.granted_address = free_slots[slot_head];
          slot_head = (slot_head + 1) % POOL_SLOTS;
          slot_fill--;
          live_count++;
          held_blocks.push_back(res.granted_address);
        end
      end
      ACT_FREE: begin
        n_free_cmds++;
        if (cmd.block_address < reg_base || cmd.block_address > pool_top()) begin
          res.status = ST_OUTSIDE;
        end else if (live_count == 0) begin
          res.status = ST_NONE_ALLOCATED;
        end else begin
          push_free_slot(cmd.block_address);
          live_count--;
        end
      end
      ACT_REBUILD: begin
        n_rebuild_cmds++;
        slot_head = 0;
        slot_tail = 0;
        slot_fill = 0;
        for (int unsigned i = 0; i < lim; i++) push_free_slot(reg_base + i * stride);
        live_count = 0;
        held_blocks.delete();
        res.status = ST_REBUILT;
      end
      default: begin
        n_nop_cmds++;
      end
    endcase
    res.allocated_count = COUNT_W'(live_count);
    case (res.status)
      ST_OK:             if (cmd.action == ACT_ALLOC) n_granted++;
      ST_EXHAUSTED:      n_exhausted++;
      ST_OUTSIDE:        n_outside++;
      ST_NONE_ALLOCATED: n_none_allocated++;
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
  endtask

  // one command transaction; start stays high when the next command follows at once
  task automatic send_cmd(input logic [ACTION_W-1:0] act, input logic [ADDR_W-1:0] addr);
    fbpa_in_t  cmd;
    fbpa_out_t res;
    cmd.action = act;
    cmd.block_address = addr;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= cmd;
    do @(posedge clk); while (busy);
    apply_command(cmd, res);
    pending_results.push_back(res);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || busy);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BASE_ADDRESS: reg_base = data;
      REG_OBJECT_SIZE:  reg_size = data[SIZE_W-1:0];
      REG_MAX_OBJECTS:  reg_max  = data[LIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_pool(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size,
                              input logic [LIM_W-1:0] maxo);
    settle();
    cfg_write(REG_BASE_ADDRESS, base);
    cfg_write(REG_OBJECT_SIZE, 32'(size));
    cfg_write(REG_MAX_OBJECTS, 32'(maxo));
    cfg_valid <= 1'b0;
  endtask

  task automatic test_before_first_rebuild();
    send_cmd(ACT_ALLOC, '0);
    send_cmd(ACT_FREE, '0);
    send_cmd(ACT_FREE, 32'hFFFF_FFFF);
    send_cmd(ACT_NOP, 32'hFFFF_FFFF);
  endtask

  // zero limit acts as one block, zero size gives the minimum stride
  task automatic test_single_block_pool();
    program_pool(32'h0000_0010, '0, '0);
    send_cmd(ACT_REBUILD, '0);
    send_cmd(ACT_ALLOC, '0);
    send_cmd(ACT_ALLOC, '0);
    send_cmd(ACT_FREE, 32'h0000_0014);
    send_cmd(ACT_FREE, 32'h0000_000C);
    send_cmd(ACT_FREE, 32'h0000_0010);
    send_cmd(ACT_FREE, 32'h0000_0010);
    send_cmd(ACT_ALLOC, '0);
    // raise the limit without a rebuild: the ring is empty
    settle();
    cfg_write(REG_MAX_OBJECTS, 32'd2);
    cfg_valid <= 1'b0;
    send_cmd(ACT_ALLOC, '0);
  endtask

  task automatic test_wrapping_region();
    program_pool(32'hFFFF_FFFF, SIZE_W'(5), LIM_W'(4));
    send_cmd(ACT_REBUILD, $urandom);
    repeat (4) send_cmd(ACT_ALLOC, $urandom);
    send_cmd(ACT_FREE, 32'hFFFF_FFFF);
    send_cmd(ACT_FREE, 32'h0000_0007);
  endtask

  task automatic test_largest_stride();
    program_pool('0, '1, '1);
    send_cmd(ACT_REBUILD, $urandom);
    send_cmd(ACT_ALLOC, $urandom);
    send_cmd(ACT_ALLOC, $urandom);
    send_cmd(ACT_FREE, 32'h07FE_0000);
    send_cmd(ACT_FREE, 32'h07FE_0001);
  endtask

  // mostly allocate/free of granted blocks in alternating bursts, plus stray traffic
  task automatic test_random_traffic(input int idle_pct, input logic [ADDR_W-1:0] base,
                                     input logic [SIZE_W-1:0] size,
                                     input logic [LIM_W-1:0] maxo, input int n_items);
    logic [ADDR_W-1:0] lo_addr;
    logic [ADDR_W-1:0] hi_addr;
    logic [ADDR_W-1:0] pick;
    int unsigned       roll;
    int unsigned       alloc_share;
    int                k;
    program_pool(base, size, maxo);
    sender_idle_pct = idle_pct;
    send_cmd(ACT_REBUILD, $urandom);
    alloc_share = 60;
    for (int n = 0; n < n_items; n++) begin
      if (n == n_items / 2) begin
        settle();
        cfg_write(REG_MAX_OBJECTS, $urandom_range(0, 2047));
        cfg_valid <= 1'b0;
      end
      if (n % 40 == 0) alloc_share = $urandom_range(0, 1) ? 60 : 25;
      lo_addr = reg_base;
      hi_addr = pool_top();
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        send_cmd(ACT_REBUILD, $urandom);
      end else if (roll < 2 + alloc_share) begin
        send_cmd(ACT_ALLOC, $urandom);
      end else if (roll < 87 && held_blocks.size() != 0) begin
        k = $urandom_range(0, held_blocks.size() - 1);
        pick = held_blocks[k];
        held_blocks.delete(k);
        send_cmd(ACT_FREE, pick);
      end else if (roll < 91) begin
        send_cmd(ACT_FREE, lo_addr + $urandom_range(0, hi_addr - lo_addr));
      end else if (roll < 95) begin
        if (lo_addr != 0 && (hi_addr == '1 || $urandom_range(0, 1)))
          pick = $urandom_range(0, lo_addr - 1);
        else if (hi_addr != '1)
          pick = $urandom_range(hi_addr + 1, 32'hFFFF_FFFF);
        else
          pick = $urandom;
        send_cmd(ACT_FREE, pick);
      end else if (roll < 97) begin
        send_cmd(ACT_NOP, $urandom);
      end else begin
        send_cmd(ACT_FREE, $urandom);
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    fbpa_out_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no command pending", '0, 64'(out_result.status));
      end else begin
        want = pending_results.pop_front();
        if (out_result.status !== want.status)
          report_mismatch("status", 64'(want.status), 64'(out_result.status));
        if (out_result.granted_address !== want.granted_address)
          report_mismatch("granted_address", 64'(want.granted_address),
                          64'(out_result.granted_address));
        if (out_result.allocated_count !== want.allocated_count)
          report_mismatch("allocated_count", 64'(want.allocated_count),
                          64'(out_result.allocated_count));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("fixed_block_pool_allocator_tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_before_first_rebuild();
    test_single_block_pool();
    test_wrapping_region();
    test_largest_stride();
    test_random_traffic(34, $urandom, SIZE_W'($urandom_range(0, 131071)),
                        LIM_W'($urandom_range(0, 2047)), 475);
    test_random_traffic(67, '0, SIZE_W'(65536), LIM_W'(1024), 475);
    test_random_traffic(0, 32'hFFFF_FFFC, SIZE_W'(1), LIM_W'(16), 475);

    settle();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", '0, 64'(pending_results.size()));

    $display("ran %0d alloc, %0d free, %0d rebuild and %0d no-op transactions",
             n_alloc_cmds, n_free_cmds, n_rebuild_cmds, n_nop_cmds);
    $display("saw %0d grants, %0d exhausted, %0d out of range, %0d frees with none held",
             n_granted, n_exhausted, n_outside, n_none_allocated);
    if (mismatch_count == 0) begin
      $display("fixed_block_pool_allocator_tb: PASS");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("fixed_block_pool_allocator_tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> fixed_block_pool_allocator.f
hw/rtl/fbpa_pkg.sv
hw/rtl/fbpa_ram.sv
hw/rtl/fixed_block_pool_allocator.sv
tb/sv/fixed_block_pool_allocator_tb.sv
